@@ src/conv2d_relu_stream_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the conv2d ReLU stream core
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef CONV2D_RELU_STREAM_CORE_MACROS_SVH
`define CONV2D_RELU_STREAM_CORE_MACROS_SVH

// Implication checked on every edge outside reset.
`define CRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/crs_pkg.sv @@
// ----------------------------------------------------------------------------
// Package for the conv2d ReLU stream core
// Sizes, field widths and operation codes.
// ----------------------------------------------------------------------------
package crs_pkg;
	localparam int InChannels = 1;
	localparam int InSize     = 32;
	localparam int Filters    = 6;
	localparam int Kernel     = 5;

	localparam int WDepth   = Filters * InChannels * Kernel * Kernel;
	localparam int RDepth   = Kernel * InSize * InChannels;
	localparam int KTaps    = InChannels * Kernel * Kernel;
	localparam int ActMax   = 32767;

	localparam int WAW = $clog2(WDepth);
	localparam int RAW = $clog2(RDepth);
	localparam int FW  = (Filters > 1) ? $clog2(Filters) : 1;
	localparam int CHW = (InChannels > 1) ? $clog2(InChannels) : 1;
	localparam int PW  = $clog2(InSize);
	localparam int KW  = (Kernel > 1) ? $clog2(Kernel) : 1;
	localparam int ACW = 48;

	typedef logic [1:0] op_t;
	localparam op_t OpWeight = 2'd0;
	localparam op_t OpBias   = 2'd1;
	localparam op_t OpPixel  = 2'd2;
endpackage

@@ src/crs_if.sv @@
// ----------------------------------------------------------------------------
// Stream channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface crs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  index;
	logic signed [15:0] value;
	modport source (output valid, op, index, value, input ready);
	modport sink   (input valid, op, index, value, output ready);
endinterface

interface crs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  filter_id;
	logic [4:0]  out_row;
	logic [4:0]  out_col;
	logic [14:0] activation;
	logic        last;
	modport source (output valid, filter_id, out_row, out_col, activation, last,
		input ready);
	modport sink   (input valid, filter_id, out_row, out_col, activation, last,
		output ready);
endinterface

@@ src/conv2d_relu_stream_core.sv @@
// ----------------------------------------------------------------------------
// Conv2d ReLU stream core
// Valid stride-1 multi-filter 2D convolution with bias and ReLU, one shared MAC.
// ----------------------------------------------------------------------------
// A load item (weight or bias) is written into its store when it is taken. A
// pixel item is written into the circular row store when it is taken. When it
// closes a full window, the block then runs one shared multiply-accumulate
// over every filter, channel and kernel tap. For each filter it passes through
// a setup state, the MAC over InChannels*Kernel*Kernel taps, a drain of the
// multiply pipe and an output state; then a wait state hands off the last
// result. The next item is taken only after the sink has accepted that last
// result, and a sink that holds off a result holds the block in its output or
// wait state. The single MAC and the one read port on each store set how long
// a window takes. The input is not ready while a window is being computed.
// Results leave through a one-entry output register, in filter order, with
// last on the final filter. Stores power up undefined and are never cleared;
// reading an entry never written yields unspecified data.
module conv2d_relu_stream_core (
	input logic clk,
	input logic arst_n,
	crs_in_if.sink   in_ch,
	crs_out_if.source out_ch
);
	import crs_pkg::*;

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StRead = 3'd1;
	localparam logic [2:0] StMac  = 3'd2;
	localparam logic [2:0] StBias = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;
	localparam logic [2:0] StWait = 3'd5;

	logic signed [15:0] wmem [WDepth];
	logic signed [15:0] rmem [RDepth];
	logic signed [15:0] bmem [Filters];

	logic [2:0]     state_q;
	logic [PW-1:0]  prow_q, pcol_q;
	logic [CHW-1:0] pch_q;
	logic [KW-1:0]  pslot_q;          // prow mod Kernel
	logic [PW-1:0]  r0_q, c0_q;
	logic [FW-1:0]  f_q;
	logic [CHW-1:0] d_q;
	logic [KW-1:0]  kr_q, kc_q;
	logic [KW-1:0]  srow_q;           // slot of window row kr
	logic [KW-1:0]  sbase_q;          // slot of window row 0
	logic [WAW-1:0] wa_q;
	logic           tap_last_q, mac_v_s1, mac_last_s1;
	logic signed [15:0] wd_s1, rd_s1;
	logic signed [31:0] prod_s2;
	logic           prod_v_s2, prod_last_s2;
	logic signed [ACW-1:0] acc_q;
	logic [2:0]  ofid_q;
	logic [4:0]  orow_q, ocol_q;
	logic [14:0] oact_q;
	logic        olast_q, ovalid_q;

	logic in_fire, closes;
	logic [RAW-1:0] wr_slot, rd_slot;
	logic signed [ACW-1:0] fin;

	assign in_ch.ready = (state_q == StIdle);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign closes = (pch_q == CHW'(InChannels-1)) && (prow_q >= PW'(Kernel-1))
		&& (pcol_q >= PW'(Kernel-1));
	assign wr_slot = RAW'((32'(pslot_q) * InSize + 32'(pcol_q)) * InChannels
		+ 32'(pch_q));
	assign rd_slot = RAW'((32'(srow_q) * InSize + 32'(c0_q) + 32'(kc_q)) * InChannels
		+ 32'(d_q));

	// Stores.
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.op == OpWeight && 32'(in_ch.index) < WDepth)
			wmem[WAW'(in_ch.index)] <= in_ch.value;
		if (in_fire && in_ch.op == OpBias && 32'(in_ch.index) < Filters)
			bmem[FW'(in_ch.index)] <= in_ch.value;
		if (in_fire && in_ch.op == OpPixel)
			rmem[wr_slot] <= in_ch.value;
		wd_s1 <= wmem[wa_q];
		rd_s1 <= rmem[rd_slot];
		prod_s2 <= 32'(wd_s1) * 32'(rd_s1);
	end

	assign fin = acc_q + (ACW'(bmem[f_q]) <<< 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			prow_q <= '0; pcol_q <= '0; pch_q <= '0; pslot_q <= '0;
			mac_v_s1 <= 1'b0; prod_v_s2 <= 1'b0; ovalid_q <= 1'b0;
			mac_last_s1 <= 1'b0; prod_last_s2 <= 1'b0;
		end else begin
			mac_v_s1 <= 1'b0;
			prod_v_s2 <= mac_v_s1;
			prod_last_s2 <= mac_last_s1;
			// The output state either loads a new result or holds the old one.
			if (out_ch.ready && state_q != StOut) ovalid_q <= 1'b0;
			case (state_q)
			StIdle: begin
				if (in_fire && in_ch.op == OpPixel) begin
					r0_q <= prow_q - PW'(Kernel-1);
					c0_q <= pcol_q - PW'(Kernel-1);
					sbase_q <= (pslot_q == KW'(Kernel-1)) ? '0 : pslot_q + 1'b1;
					if (closes) state_q <= StRead;
					f_q <= '0;
					if (pch_q == CHW'(InChannels-1)) begin
						pch_q <= '0;
						if (pcol_q == PW'(InSize-1)) begin
							pcol_q <= '0;
							if (prow_q == PW'(InSize-1)) begin
								prow_q <= '0; pslot_q <= '0;
							end else begin
								prow_q <= prow_q + 1'b1;
								pslot_q <= (pslot_q == KW'(Kernel-1)) ? '0 : pslot_q + 1'b1;
							end
						end else pcol_q <= pcol_q + 1'b1;
					end else pch_q <= pch_q + 1'b1;
				end
			end
			StRead: begin
				// Start one filter: reset taps and accumulator.
				d_q <= '0; kr_q <= '0; kc_q <= '0; srow_q <= sbase_q;
				wa_q <= WAW'(32'(f_q) * KTaps);
				tap_last_q <= (KTaps == 1);
				acc_q <= '0;
				state_q <= StMac;
			end
			StMac: begin
				mac_v_s1 <= 1'b1;
				mac_last_s1 <= tap_last_q;
				if (!tap_last_q) begin
					wa_q <= wa_q + 1'b1;
					tap_last_q <= (32'(wa_q) + 2 == (32'(f_q) + 1) * KTaps);
					if (kc_q == KW'(Kernel-1)) begin
						kc_q <= '0;
						if (kr_q == KW'(Kernel-1)) begin
							kr_q <= '0; srow_q <= sbase_q; d_q <= d_q + 1'b1;
						end else begin
							kr_q <= kr_q + 1'b1;
							srow_q <= (srow_q == KW'(Kernel-1)) ? '0 : srow_q + 1'b1;
						end
					end else kc_q <= kc_q + 1'b1;
				end else state_q <= StBias;
			end
			StBias: begin
				// Drain the two-stage multiply pipe.
				if (prod_v_s2 && prod_last_s2) state_q <= StOut;
			end
			StOut: begin
				if (!ovalid_q || out_ch.ready) begin
					ovalid_q <= 1'b1;
					ofid_q <= 3'(f_q);
					orow_q <= 5'(r0_q);
					ocol_q <= 5'(c0_q);
					olast_q <= (f_q == FW'(Filters-1));
					if (fin <= 0) oact_q <= '0;
					else if ((fin >>> 8) > ACW'(ActMax)) oact_q <= 15'(ActMax);
					else oact_q <= 15'(fin >>> 8);
					if (f_q == FW'(Filters-1)) state_q <= StWait;
					else begin
						f_q <= f_q + 1'b1;
						state_q <= StRead;
					end
				end
			end
			StWait: begin
				if (!ovalid_q || out_ch.ready) state_q <= StIdle;
			end
			default: state_q <= StIdle;
			endcase
			if (prod_v_s2) acc_q <= acc_q + ACW'(prod_s2);
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.filter_id = ofid_q;
	assign out_ch.out_row = orow_q;
	assign out_ch.out_col = ocol_q;
	assign out_ch.activation = oact_q;
	assign out_ch.last = olast_q;
endmodule

@@ src/crs_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the conv2d ReLU stream core
// Watches the top-level channels over time.
// ----------------------------------------------------------------------------
`include "conv2d_relu_stream_core_macros.svh"

module crs_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	`CRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`CRS_ASSERT_IMPL(a_idle_empty, clk, arst_n, in_ready, !out_valid, "result pending at idle")
	`CRS_ASSERT_IMPL(a_busy_no_in, clk, arst_n, out_valid && !out_last, !in_ready, "open mid burst")
endmodule

bind conv2d_relu_stream_core crs_checker u_crs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_last(out_ch.last)
);

@@ tb/sv/conv2d_relu_stream_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the conv2d ReLU stream core
// Drives weight, bias and pixel items through the input channel and checks
// every result against a local model of the windowed convolution. The model
// covers bias, ReLU, the shift and saturation. The run fills the first kernel
// rows, then steps through several idle patterns on both channels while
// windows close.
// ----------------------------------------------------------------------------
module conv2d_relu_stream_core_tb;
	import crs_pkg::*;

	localparam op_t OpUnused = 2'd3;
	localparam int ClkLimit = 1000000;
	localparam int TailCycles = 400;
	localparam int EdgePixels = 4;
	localparam int FillPixels = (Kernel - 1) * InSize * InChannels
		+ (Kernel - 1) * InChannels - EdgePixels;

	typedef struct packed {
		logic [2:0]  filter_id;
		logic [4:0]  out_row;
		logic [4:0]  out_col;
		logic [14:0] activation;
		logic        last;
	} conv_result_t;

	logic clk;
	logic arst_n;

	crs_in_if  in_ch ();
	crs_out_if out_ch ();

	conv2d_relu_stream_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// The local copy of the coefficient and row stores, and the raster position
	// of the next pixel.
	logic signed [15:0] coef_w [WDepth];
	logic signed [15:0] coef_b [Filters];
	logic signed [15:0] line_buf [RDepth];
	int unsigned        pos_row;
	int unsigned        pos_col;
	int unsigned        pos_chan;

	conv_result_t activ_queue [$];

	int src_idle_pct;
	int sink_idle_pct;
	int fail_count;
	int items_sent;
	int pixels_sent;
	int results_checked;
	int windows_seen;
	int cycle_count;

	// Clock: 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Computes one filter's activation over the window whose top-left corner is
	// (r0, c0). Products are summed at full width before the bias is added.
	function automatic logic [14:0] window_activation(int unsigned f, int unsigned r0,
		int unsigned c0);
		longint acc;
		longint q;
		int unsigned slot_row;
		int unsigned pi;
		int unsigned wi;
		acc = 0;
		for (int unsigned d = 0; d < InChannels; d++) begin
			for (int unsigned kr = 0; kr < Kernel; kr++) begin
				slot_row = (r0 + kr) % Kernel;
				for (int unsigned kc = 0; kc < Kernel; kc++) begin
					pi = (slot_row * InSize + c0 + kc) * InChannels + d;
					wi = ((f * InChannels + d) * Kernel + kr) * Kernel + kc;
					acc += longint'(line_buf[pi]) * longint'(coef_w[wi]);
				end
			end
		end
		acc += longint'(coef_b[f]) * 256;
		if (acc <= 0) begin
			return '0;
		end
		q = acc >>> 8;
		if (q > ActMax) begin
			q = ActMax;
		end
		return q[14:0];
	endfunction

	// Applies one accepted item to the local stores and queues any results.
	function automatic void conv_predict(op_t op, logic [7:0] idx, logic signed [15:0] val);
		conv_result_t res;
		int unsigned r0;
		int unsigned c0;
		case (op)
			OpWeight: begin
				if (idx < WDepth) begin
					coef_w[idx] = val;
				end
			end
			OpBias: begin
				if (idx < Filters) begin
					coef_b[idx] = val;
				end
			end
			OpPixel: begin
				line_buf[((pos_row % Kernel) * InSize + pos_col) * InChannels + pos_chan] = val;
				if (pos_chan == InChannels - 1 && pos_row >= Kernel - 1 &&
					pos_col >= Kernel - 1) begin
					r0 = pos_row - (Kernel - 1);
					c0 = pos_col - (Kernel - 1);
					windows_seen++;
					for (int unsigned f = 0; f < Filters; f++) begin
						res.filter_id  = f[2:0];
						res.out_row    = r0[4:0];
						res.out_col    = c0[4:0];
						res.activation = window_activation(f, r0, c0);
						res.last       = (f == Filters - 1);
						activ_queue.push_back(res);
					end
				end
				pos_chan++;
				if (pos_chan >= InChannels) begin
					pos_chan = 0;
					pos_col++;
					if (pos_col >= InSize) begin
						pos_col = 0;
						pos_row++;
						if (pos_row >= InSize) begin
							pos_row = 0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Input monitor: every accepted item goes through the model at the edge
	// where it is taken.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			conv_predict(op_t'(in_ch.op), in_ch.index, in_ch.value);
			items_sent++;
			if (in_ch.op == OpPixel) begin
				pixels_sent++;
			end
		end
	end

	// Result checker: each accepted result is compared with the oldest one
	// that the model has queued.
	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (activ_queue.size() == 0) begin
				$error("unexpected result: filter %0d row %0d col %0d", out_ch.filter_id,
					out_ch.out_row, out_ch.out_col);
				fail_count++;
			end else begin
				exp_res = activ_queue.pop_front();
				results_checked++;
				if (out_ch.filter_id !== exp_res.filter_id) begin
					$error("filter_id: expected %0d, got %0d", exp_res.filter_id,
						out_ch.filter_id);
					fail_count++;
				end
				if (out_ch.out_row !== exp_res.out_row) begin
					$error("out_row: expected %0d, got %0d", exp_res.out_row, out_ch.out_row);
					fail_count++;
				end
				if (out_ch.out_col !== exp_res.out_col) begin
					$error("out_col: expected %0d, got %0d", exp_res.out_col, out_ch.out_col);
					fail_count++;
				end
				if (out_ch.activation !== exp_res.activation) begin
					$error("activation: expected %0d, got %0d", exp_res.activation,
						out_ch.activation);
					fail_count++;
				end
				if (out_ch.last !== exp_res.last) begin
					$error("last: expected %0d, got %0d", exp_res.last, out_ch.last);
					fail_count++;
				end
			end
		end
	end

	// The receiver stalls at random according to the current idle rate.
	always @(posedge clk) begin
		if (arst_n) begin
			out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > ClkLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offers one item and holds it until the block takes it. Random gaps come
	// before the item, so valid is only lowered when a gap is taken.
	task automatic send_item(op_t op, logic [7:0] idx, logic signed [15:0] val);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) begin
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.op    <= op;
		in_ch.index <= idx;
		in_ch.value <= val;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Lowers valid and waits until every queued result has come back.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (activ_queue.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly small values so sums land in the middle of the range, with full
	// range values and the two extremes mixed in.
	function automatic logic signed [15:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 5) begin
			return 16'($signed($urandom_range(1024)) - 512);
		end else if (sel < 8) begin
			return 16'($urandom);
		end else if (sel == 8) begin
			return 16'sh7fff;
		end
		return 16'sh8000;
	endfunction

	// Extremes of the load fields and the items that must be ignored.
	task automatic test_directed_loads();
		send_item(OpWeight, 8'd0, 16'sh7fff);
		send_item(OpWeight, 8'(WDepth - 1), 16'sh8000);
		send_item(OpWeight, 8'(WDepth), 16'sh1234);
		send_item(OpWeight, 8'hff, 16'shffff);
		send_item(OpBias, 8'd0, 16'sh7fff);
		send_item(OpBias, 8'(Filters - 1), 16'sh8000);
		send_item(OpBias, 8'(Filters), 16'sh0001);
		send_item(OpBias, 8'hff, 16'sh5555);
		send_item(OpUnused, 8'haa, 16'shaaaa);
		send_item(OpUnused, 8'h55, 16'sh5555);
		send_item(OpWeight, 8'd1, 16'sh0000);
		send_item(OpBias, 8'd1, 16'sh0000);
	endtask

	// Every coefficient is written before any window can read it.
	task automatic test_load_all_coeffs();
		for (int i = 0; i < WDepth; i++) begin
			send_item(OpWeight, 8'(i), pick_value());
		end
		for (int i = 0; i < Filters; i++) begin
			send_item(OpBias, 8'(i), pick_value());
		end
	endtask

	// A few extreme pixels at the start of the image so the first windows see
	// them.
	task automatic test_edge_pixels();
		send_item(OpPixel, 8'hff, 16'sh7fff);
		send_item(OpPixel, 8'h00, 16'sh8000);
		send_item(OpPixel, 8'h5a, 16'sh0000);
		send_item(OpPixel, 8'ha5, 16'shffff);
	endtask

	// Fills the rows above the first window so that the next pixel closes it.
	task automatic test_fill_rows();
		for (int i = 0; i < FillPixels; i++) begin
			send_item(OpPixel, 8'($urandom), pick_value());
		end
	endtask

	// Random stream: mostly pixels, with coefficient reloads, out-of-range
	// loads and unused opcodes mixed in. Halfway through, the sender holds off
	// until the block has delivered everything that is owed.
	task automatic test_random_mix(int n_items);
		int unsigned sel;
		for (int i = 0; i < n_items; i++) begin
			if (i == n_items / 2) begin
				drain_results();
			end
			sel = $urandom_range(99);
			if (sel < 6) begin
				send_item(OpWeight, 8'($urandom_range(WDepth - 1)), pick_value());
			end else if (sel < 8) begin
				send_item(OpWeight, 8'($urandom_range(255, WDepth)), pick_value());
			end else if (sel < 11) begin
				send_item(OpBias, 8'($urandom_range(Filters - 1)), pick_value());
			end else if (sel < 13) begin
				send_item(OpBias, 8'($urandom_range(255, Filters)), pick_value());
			end else if (sel < 15) begin
				send_item(OpUnused, 8'($urandom), 16'($urandom));
			end else begin
				send_item(OpPixel, 8'($urandom), pick_value());
			end
		end
	endtask

	initial begin
		fail_count      = 0;
		items_sent      = 0;
		pixels_sent     = 0;
		results_checked = 0;
		windows_seen    = 0;
		cycle_count     = 0;
		pos_row         = 0;
		pos_col         = 0;
		pos_chan        = 0;
		src_idle_pct    = 27;
		sink_idle_pct   = 54;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.op        = OpWeight;
		in_ch.index     = '0;
		in_ch.value     = '0;
		out_ch.ready    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_loads();
		test_load_all_coeffs();
		test_edge_pixels();
		test_fill_rows();
		test_random_mix(20);
		drain_results();

		src_idle_pct  = 54;
		sink_idle_pct = 27;
		test_random_mix(20);
		drain_results();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_mix(20);
		drain_results();

		repeat (TailCycles) @(posedge clk);
		$display("Sent %0d items (%0d pixels), %0d windows closed.", items_sent,
			pixels_sent, windows_seen);
		$display("Checked %0d results across three idle patterns on both channels.",
			results_checked);
		if (fail_count == 0 && activ_queue.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

@@ conv2d_relu_stream_core.f @@
+incdir+src
src/crs_pkg.sv
src/crs_if.sv
src/conv2d_relu_stream_core.sv
src/crs_checker.sv
tb/sv/conv2d_relu_stream_core_tb.sv
